// ----- hw/rtl/a32lsd_pkg.sv -----
// Shared types, codes and constants for the A32 load/store decode and address unit.
package a32lsd_pkg;

  localparam int unsigned ListW = 16;
  localparam int unsigned CntW  = 5;

  typedef enum logic [2:0] {
    KIND_UNSUP  = 3'd0,
    KIND_PREF   = 3'd1,
    KIND_SINGLE = 3'd2,
    KIND_BLOCK  = 3'd3,
    KIND_LDEX   = 3'd4,
    KIND_STEX   = 3'd5,
    KIND_SWAP   = 3'd6
  } kind_t;

  localparam logic [1:0] WID_BYTE = 2'd0;
  localparam logic [1:0] WID_HALF = 2'd1;
  localparam logic [1:0] WID_WORD = 2'd2;
  localparam logic [1:0] WID_DBL  = 2'd3;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic        is_load;
    logic [1:0]  width;
    logic        sx;
    logic [3:0]  dreg;
    logic [3:0]  areg;
    logic        up;
    logic        pre;
    logic        wbe;
    logic        rej;
    logic [ListW-1:0] list;
  } dec_t;

  function automatic logic [31:0] shift_imm(input logic [31:0] v, input logic [1:0] ty,
                                            input logic [4:0] amt, input logic c);
    logic [31:0] r;
    r = v;
    unique case (ty)
      SH_LSL: r = v << amt;
      SH_LSR: r = (amt == 5'd0) ? 32'd0 : (v >> amt);
      SH_ASR: r = (amt == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
      SH_ROR: r = (amt == 5'd0) ? {c, v[31:1]} : ((v >> amt) | (v << (6'd32 - {1'b0, amt})));
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/a32_load_store_decode_agu.sv -----
// Top level: three-stage decode and address pipeline with block-transfer sequencer.
//  channel | ports                                   | handshake
//  in      | instr pc base_reg_value index_reg_value carry_in | in_valid/in_ready
//  out     | kind .. last (11 fields)                 | out_valid/out_ready
// Stage 1 decodes and forms the offset, stage 2 adds base and offset, stage 3
// walks the register list, one word per cycle unless out_ready holds it; the
// output register follows. Single, swap, exclusive, prefetch and rejected
// words give one result word each; LDM/STM give one word per listed
// register. The first result word passes stages 1 to 3 and the output register.
// Reset clears valid bits only. Low out_ready holds full stages; empty ones still fill.
module a32_load_store_decode_agu
  import a32lsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr,
  input  logic [31:0] in_pc,
  input  logic [31:0] in_base_reg_value,
  input  logic [31:0] in_index_reg_value,
  input  logic        in_carry_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic        out_is_load,
  output logic [1:0]  out_access_width,
  output logic        out_sign_extend,
  output logic [3:0]  out_data_reg,
  output logic [3:0]  out_aux_reg,
  output logic [31:0] out_access_address,
  output logic        out_writeback_enable,
  output logic [31:0] out_writeback_value,
  output logic [31:0] out_reg15_read_value,
  output logic        out_last
);

  dec_t        dec;
  a32lsd_decode u_dec (.instr(in_instr), .dec(dec));

  // stage 1
  logic        v1_r;
  dec_t        d1_r;
  logic [31:0] base1_r, off1_r, p8_1_r;
  logic [CntW-1:0] cnt1_r;
  // stage 2
  logic        v2_r;
  dec_t        d2_r;
  logic [31:0] base2_r, adj2_r, p8_2_r, a0_2_r, fin2_r;
  // stage 3 / sequencer
  logic        v3_r;
  dec_t        d3_r;
  logic [31:0] addr3_r, adj3_r, base3_r, p8_3_r, fin3_r;
  logic [ListW-1:0] rem3_r;
  // output
  logic        vo_r;

  logic s3_take, s3_done, adv3, adv2, adv1, o_ld;
  logic [31:0] p8, base, idx, off, bytes1;
  logic [CntW-1:0] cnt;
  logic [3:0] rn, rm, low;
  logic [ListW-1:0] rem_nxt;

  always_comb begin
    p8 = in_pc + 32'd8;
    rn = in_instr[19:16];
    rm = in_instr[3:0];
    base = (rn == 4'hF) ? p8 : in_base_reg_value;
    idx = (rm == 4'hF) ? p8 : in_index_reg_value;
    if (in_instr[27:25] == 3'b010) off = {20'd0, in_instr[11:0]};
    else if (in_instr[27:25] == 3'b011)
      off = shift_imm(idx, in_instr[6:5], in_instr[11:7], in_carry_in);
    else if (in_instr[22]) off = {24'd0, in_instr[11:8], in_instr[3:0]};
    else off = idx;
    cnt = '0;
    for (int k = 0; k < ListW; k++) cnt = cnt + CntW'(in_instr[k]);
  end

  assign o_ld = !vo_r || out_ready;
  assign s3_done = v3_r && (d3_r.kind != KIND_BLOCK || d3_r.rej ||
                            (rem3_r & (rem3_r - 16'd1)) == '0);
  assign adv3 = !v3_r || (s3_done && o_ld);
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;
  assign s3_take = v3_r && o_ld;

  always_comb begin
    low = '0;
    for (int k = ListW - 1; k >= 0; k--) if (rem3_r[k]) low = 4'(k);
    rem_nxt = rem3_r;
    rem_nxt[low] = 1'b0;
  end

  assign bytes1 = {25'd0, cnt1_r, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (o_ld) vo_r <= v3_r;
    end
    if (adv1) begin
      d1_r <= dec;
      base1_r <= base;
      off1_r <= off;
      p8_1_r <= p8;
      cnt1_r <= cnt;
    end
    if (adv2) begin
      d2_r <= d1_r;
      base2_r <= base1_r;
      p8_2_r <= p8_1_r;
      adj2_r <= d1_r.up ? base1_r + off1_r : base1_r - off1_r;
      a0_2_r <= d1_r.up ? base1_r + (d1_r.pre ? 32'd4 : 32'd0)
                        : base1_r - bytes1 + (d1_r.pre ? 32'd0 : 32'd4);
      fin2_r <= d1_r.up ? base1_r + bytes1 : base1_r - bytes1;
    end
    if (adv3) begin
      d3_r <= d2_r;
      base3_r <= base2_r;
      p8_3_r <= p8_2_r;
      rem3_r <= d2_r.list;
      adj3_r <= d2_r.kind == KIND_BLOCK ? a0_2_r : adj2_r;
      addr3_r <= a0_2_r;
      fin3_r <= fin2_r;
    end else if (s3_take) begin
      rem3_r <= rem_nxt;
      addr3_r <= addr3_r + 32'd4;
    end
    if (o_ld && v3_r) begin
      out_kind <= d3_r.rej ? KIND_UNSUP : d3_r.kind;
      out_last <= s3_done;
      out_is_load <= 1'b0;
      out_access_width <= '0;
      out_sign_extend <= 1'b0;
      out_data_reg <= '0;
      out_aux_reg <= '0;
      out_access_address <= '0;
      out_writeback_enable <= 1'b0;
      out_writeback_value <= '0;
      out_reg15_read_value <= '0;
      if (!d3_r.rej) begin
        out_reg15_read_value <= p8_3_r;
        if (d3_r.kind != KIND_PREF) begin
          out_is_load <= d3_r.is_load;
          out_access_width <= d3_r.width;
          out_sign_extend <= d3_r.sx;
          out_data_reg <= d3_r.dreg;
          out_aux_reg <= d3_r.areg;
          out_access_address <= base3_r;
        end
        if (d3_r.kind == KIND_SINGLE) begin
          out_access_address <= d3_r.pre ? adj3_r : base3_r;
          out_writeback_enable <= d3_r.wbe;
          out_writeback_value <= adj3_r;
        end
        if (d3_r.kind == KIND_BLOCK) begin
          out_data_reg <= low;
          out_access_address <= addr3_r;
          out_writeback_enable <= d3_r.wbe;
          out_writeback_value <= d3_r.wbe ? fin3_r : 32'd0;
          if (!d3_r.is_load) out_reg15_read_value <= p8_3_r + 32'd4;
        end
      end
    end
  end

  assign out_valid = vo_r;

endmodule

// ----- hw/rtl/a32lsd_decode.sv -----
// Instruction classification and encoding rejection.
module a32lsd_decode
  import a32lsd_pkg::*;
(
  input  logic [31:0] instr,
  output dec_t        dec
);

  logic [3:0] rn, rd, rm, rt;
  logic       cond_f, pre, up, wb, lb, regoff, hw_imm;
  logic [7:0] op8;
  logic [1:0] mop;

  always_comb begin
    rn = instr[19:16];
    rd = instr[15:12];
    rm = instr[3:0];
    cond_f = instr[31:28] == 4'hF;
    pre = instr[24];
    up = instr[23];
    wb = instr[21];
    lb = instr[20];
    op8 = instr[27:20];
    mop = instr[6:5];
    regoff = instr[25];
    hw_imm = instr[22];
    rt = rd;
    dec = '0;
    dec.kind = KIND_UNSUP;
    dec.up = up;
    dec.pre = pre;
    dec.list = instr[15:0];
    if (((instr & 32'hFF30F000) == 32'hF510F000) || ((instr & 32'hFF30F010) == 32'hF710F000) ||
        ((instr & 32'hFF70F000) == 32'hF450F000) || ((instr & 32'hFF70F010) == 32'hF650F000)) begin
      dec.kind = KIND_PREF;
    end else if (!cond_f && op8[7:3] == 5'b00011 && instr[11:4] == 8'hF9) begin
      rt = lb ? rd : rm;
      dec.kind = lb ? KIND_LDEX : KIND_STEX;
      dec.is_load = lb;
      unique case (op8[2:1])
        2'd0: dec.width = WID_WORD;
        2'd1: dec.width = WID_DBL;
        2'd2: dec.width = WID_BYTE;
        default: dec.width = WID_HALF;
      endcase
      if (lb && rm != 4'hF) dec.rej = 1'b1;
      if (rn == 4'hF || rd == 4'hF || rt == 4'hF) dec.rej = 1'b1;
      if (dec.width == WID_DBL) begin
        rt[0] = 1'b0;
        if (rt >= 4'd14) dec.rej = 1'b1;
      end
      dec.dreg = rt;
      dec.areg = rd;
    end else if (!cond_f && (instr & 32'h0FB000F0) == 32'h01000090) begin
      dec.kind = KIND_SWAP;
      dec.is_load = 1'b1;
      dec.width = instr[22] ? WID_BYTE : WID_WORD;
      dec.dreg = rm;
      dec.areg = rd;
      if (rn == 4'hF || rd == 4'hF || rm == 4'hF) dec.rej = 1'b1;
    end else if ((instr & 32'h0E000000) == 32'h08000000) begin
      dec.kind = KIND_BLOCK;
      dec.is_load = lb;
      dec.width = WID_WORD;
      dec.areg = rn;
      dec.wbe = wb;
      if (cond_f || instr[15:0] == 16'd0 || instr[22] || rn == 4'hF ||
          (wb && instr[rn])) dec.rej = 1'b1;
    end else if (!cond_f && (instr & 32'h0C000000) == 32'h04000000) begin
      dec.kind = KIND_SINGLE;
      dec.width = instr[22] ? WID_BYTE : WID_WORD;
      dec.is_load = lb;
      dec.dreg = rt;
      dec.areg = rn;
      dec.wbe = !pre || wb;
      if (regoff && instr[4]) dec.rej = 1'b1;
      if (lb && rt == 4'hF && dec.width != WID_WORD) dec.rej = 1'b1;
    end else if (!cond_f && (instr & 32'h0E000090) == 32'h00000090) begin
      dec.kind = KIND_SINGLE;
      dec.dreg = rt;
      dec.areg = rn;
      dec.wbe = !pre || wb;
      unique case (mop)
        2'd1: begin dec.width = WID_HALF; dec.is_load = lb; end
        2'd2: begin dec.width = lb ? WID_BYTE : WID_DBL; dec.is_load = 1'b1; dec.sx = lb; end
        2'd3: begin dec.width = lb ? WID_HALF : WID_DBL; dec.is_load = lb; dec.sx = lb; end
        default: dec.rej = 1'b1;
      endcase
      if (!hw_imm && !pre && wb && !lb && mop == 2'd1 && instr[11:8] != 4'd0) dec.rej = 1'b1;
      if (dec.width == WID_DBL && rt >= 4'd14) dec.rej = 1'b1;
      if (dec.is_load && rt == 4'hF) dec.rej = 1'b1;
      if (dec.width == WID_DBL && !pre && wb) dec.rej = 1'b1;
    end
    if (dec.kind == KIND_UNSUP) dec.rej = 1'b1;
  end

endmodule

// ----- hw/rtl/a32lsd_checker.sv -----
// Port-level checker for the load/store decode unit, bound to the top level.
module a32lsd_checker
  import a32lsd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic        out_last,
  input logic        out_writeback_enable,
  input logic [31:0] out_writeback_value
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped under stall");

  a_unsup_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BLOCK |-> out_last)
    else $error("non-block word without last");

  a_nowb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_UNSUP || out_kind == KIND_PREF || out_kind == KIND_SWAP)
    |-> !out_writeback_enable && out_writeback_value == 32'd0)
    else $error("writeback on class without base update");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind a32_load_store_decode_agu a32lsd_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind), .out_last(out_last),
  .out_writeback_enable(out_writeback_enable), .out_writeback_value(out_writeback_value)
);
